/* hw/rtl/tas_pkg.sv */
// ----------------------------------------------------------------------------
// Top three area selector package
// Shared field types and the record structure passed to the ranking unit.
// ----------------------------------------------------------------------------
package tas_pkg;

  localparam int SIDE_W = 16;
  localparam int AREA_W = 32;
  localparam int TAG_W  = 16;
  localparam int RANK_W = 2;

  typedef logic [SIDE_W-1:0] side_t;
  typedef logic [AREA_W-1:0] area_t;
  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [RANK_W-1:0] rank_t;

  typedef struct packed {
    side_t width_q8_8;
    side_t height_q8_8;
    tag_t  record_tag;
    logic  last_of_set;
  } rec_t;

endpackage

/* hw/rtl/top_three_area_selector.sv */
// ----------------------------------------------------------------------------
// Top three area selector
// Flow: a record is registered, then ranked from that register; results
// of a set come from snapshot registers taken when its last record ranks.
// Throughput: one record per cycle unless in_stall; a set drains TOP_COUNT
// results at one per cycle while out_stall is low, and a last record
// stalls the input until the previous ranking has fully drained.
// Reset: synchronous active-low rst_n empties the pipeline and clears slots.
// ----------------------------------------------------------------------------
module top_three_area_selector #(
  parameter int TOP_COUNT = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tas_pkg::side_t       in_width_q8_8,
  input  tas_pkg::side_t       in_height_q8_8,
  input  tas_pkg::tag_t        in_record_tag,
  input  logic                 in_last_of_set,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tas_pkg::rank_t       out_rank,
  output tas_pkg::area_t       out_area_q16_16,
  output tas_pkg::tag_t        out_winner_tag,
  output logic                 out_slot_valid,
  output logic                 out_last_result
);
  import tas_pkg::*;

  localparam int IDX_W = $clog2(TOP_COUNT > 1 ? TOP_COUNT : 2);

  rec_t             rec_r;
  logic             rec_valid_r;
  logic             go;
  logic             out_free;
  logic             out_end;
  area_t            upd_area [TOP_COUNT];
  tag_t             upd_tag  [TOP_COUNT];
  area_t            snap_area_r [TOP_COUNT];
  tag_t             snap_tag_r  [TOP_COUNT];
  logic             busy_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W:0]   rank_sum;

  assign out_end  = idx_r == IDX_W'(TOP_COUNT - 1);
  assign out_free = !busy_r || (!out_stall && out_end);
  assign go       = rec_valid_r && (!rec_r.last_of_set || out_free);
  assign in_stall = rec_valid_r && !go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_valid_r <= 1'b0;
    end else if (!in_stall) begin
      rec_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      rec_r.width_q8_8  <= in_width_q8_8;
      rec_r.height_q8_8 <= in_height_q8_8;
      rec_r.record_tag  <= in_record_tag;
      rec_r.last_of_set <= in_last_of_set;
    end
  end

  tas_rank #(
    .TOP_COUNT(TOP_COUNT)
  ) u_rank (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go),
    .rec     (rec_r),
    .upd_area(upd_area),
    .upd_tag (upd_tag)
  );

  // hold the finished ranking and advance one result per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (go && rec_r.last_of_set) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (busy_r && !out_stall) begin
      busy_r <= !out_end;
      idx_r  <= idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (go && rec_r.last_of_set) begin
      for (int i = 0; i < TOP_COUNT; i++) begin
        snap_area_r[i] <= upd_area[i];
        snap_tag_r[i]  <= upd_tag[i];
      end
    end
  end

  assign rank_sum        = {1'b0, idx_r} + (IDX_W + 1)'(1);
  assign out_valid       = busy_r;
  assign out_rank        = rank_sum[RANK_W-1:0];
  assign out_area_q16_16 = snap_area_r[idx_r];
  assign out_slot_valid  = snap_area_r[idx_r] != '0;
  assign out_winner_tag  = out_slot_valid ? snap_tag_r[idx_r] : '0;
  assign out_last_result = out_end;

endmodule

/* hw/rtl/tas_rank.sv */
// ----------------------------------------------------------------------------
// Ranking slots
// Forms the area, inserts it into the sorted slots; a last record clears them.
// ----------------------------------------------------------------------------
module tas_rank #(
  parameter int TOP_COUNT = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  tas_pkg::rec_t rec,
  output tas_pkg::area_t upd_area [TOP_COUNT],
  output tas_pkg::tag_t  upd_tag  [TOP_COUNT]
);
  import tas_pkg::*;

  area_t          slot_area_r [TOP_COUNT];
  tag_t           slot_tag_r  [TOP_COUNT];
  area_t          area;
  logic [TOP_COUNT-1:0] gt;

  assign area = area_t'(rec.width_q8_8) * area_t'(rec.height_q8_8);

  for (genvar i = 0; i < TOP_COUNT; i++) begin : g_slot
    assign gt[i] = area > slot_area_r[i];
    if (i == 0) begin : g_head
      always_comb begin
        upd_area[i] = gt[i] ? area : slot_area_r[i];
        upd_tag[i]  = gt[i] ? rec.record_tag : slot_tag_r[i];
      end
    end else begin : g_body
      always_comb begin
        if (!gt[i]) begin
          upd_area[i] = slot_area_r[i];
          upd_tag[i]  = slot_tag_r[i];
        end else if (gt[i-1]) begin
          upd_area[i] = slot_area_r[i-1];
          upd_tag[i]  = slot_tag_r[i-1];
        end else begin
          upd_area[i] = area;
          upd_tag[i]  = rec.record_tag;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOP_COUNT; i++) begin
        slot_area_r[i] <= '0;
        slot_tag_r[i]  <= '0;
      end
    end else if (go) begin
      for (int i = 0; i < TOP_COUNT; i++) begin
        slot_area_r[i] <= rec.last_of_set ? '0 : upd_area[i];
        slot_tag_r[i]  <= rec.last_of_set ? '0 : upd_tag[i];
      end
    end
  end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// Top three area selector testbench
// Streams sets of width/height records into the selector and predicts the
// three largest areas of each set. Every ranking result is checked field by
// field against the prediction. Both channels idle at random, the receiver
// holds off for a long stretch, and the sender pauses for a full drain.
// ----------------------------------------------------------------------------
module tb_top;
  import tas_pkg::*;

  localparam int SLOTS = 3;

  typedef struct {
    rank_t rank;
    area_t area;
    tag_t  tag;
    logic  slot_valid;
    logic  last;
  } ranking_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  side_t in_width_q8_8 = '0;
  side_t in_height_q8_8 = '0;
  tag_t  in_record_tag = '0;
  logic  in_last_of_set = 1'b0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  rank_t out_rank;
  area_t out_area_q16_16;
  tag_t  out_winner_tag;
  logic  out_slot_valid;
  logic  out_last_result;

  area_t    best_area[SLOTS];
  tag_t     best_tag[SLOTS];
  ranking_t ranking_q[$];
  int       mismatches = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  bit       long_hold = 1'b0;

  top_three_area_selector #(.TOP_COUNT(SLOTS)) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_width_q8_8   (in_width_q8_8),
    .in_height_q8_8  (in_height_q8_8),
    .in_record_tag   (in_record_tag),
    .in_last_of_set  (in_last_of_set),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rank        (out_rank),
    .out_area_q16_16 (out_area_q16_16),
    .out_winner_tag  (out_winner_tag),
    .out_slot_valid  (out_slot_valid),
    .out_last_result (out_last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void rank_record(side_t w, side_t h, tag_t tag, logic last);
    area_t    area;
    int       pos;
    ranking_t r;
    area = area_t'(w) * area_t'(h);
    pos = SLOTS;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (area > best_area[i]) pos = i;
    end
    if (pos < SLOTS) begin
      for (int j = SLOTS - 1; j > pos; j--) begin
        best_area[j] = best_area[j-1];
        best_tag[j]  = best_tag[j-1];
      end
      best_area[pos] = area;
      best_tag[pos]  = tag;
    end
    if (last) begin
      for (int k = 0; k < SLOTS; k++) begin
        r.rank       = rank_t'(k + 1);
        r.area       = best_area[k];
        r.slot_valid = (best_area[k] != '0);
        r.tag        = r.slot_valid ? best_tag[k] : '0;
        r.last       = (k == SLOTS - 1);
        ranking_q.push_back(r);
      end
      for (int k = 0; k < SLOTS; k++) begin
        best_area[k] = '0;
        best_tag[k]  = '0;
      end
    end
  endfunction

  task automatic send_record(side_t w, side_t h, tag_t tag, logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_width_q8_8  <= w;
    in_height_q8_8 <= h;
    in_record_tag  <= tag;
    in_last_of_set <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rank_record(w, h, tag, last);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (ranking_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic side_t pick_side();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2, 3: return side_t'($urandom_range(0, 7));
      4:       return side_t'($urandom_range(16'hFFF0, 16'hFFFF));
      default: return side_t'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Checker: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    ranking_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (ranking_q.size() == 0) begin
        $error("unexpected result: rank %0d area %0h tag %0h", out_rank,
               out_area_q16_16, out_winner_tag);
        mismatches++;
      end else begin
        exp_r = ranking_q.pop_front();
        if (out_rank !== exp_r.rank) begin
          $error("rank: expected %0d, actual %0d", exp_r.rank, out_rank);
          mismatches++;
        end
        if (out_area_q16_16 !== exp_r.area) begin
          $error("area_q16_16: expected %0h, actual %0h", exp_r.area, out_area_q16_16);
          mismatches++;
        end
        if (out_winner_tag !== exp_r.tag) begin
          $error("winner_tag: expected %0h, actual %0h", exp_r.tag, out_winner_tag);
          mismatches++;
        end
        if (out_slot_valid !== exp_r.slot_valid) begin
          $error("slot_valid: expected %0b, actual %0b", exp_r.slot_valid, out_slot_valid);
          mismatches++;
        end
        if (out_last_result !== exp_r.last) begin
          $error("last_result: expected %0b, actual %0b", exp_r.last, out_last_result);
          mismatches++;
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when requested
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        for (int i = 0; i < 80; i++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
        long_hold = 1'b0;
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic test_extreme_sides();
    send_record(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_record(16'h0000, 16'hFFFF, 16'h0001, 1'b0);
    send_record(16'hFFFF, 16'h0000, 16'h0002, 1'b1);
    send_record(16'h0000, 16'h0000, 16'hFFFF, 1'b1);
    send_record(16'h0001, 16'h0001, 16'h0000, 1'b1);
  endtask

  task automatic test_equal_areas();
    send_record(16'd2, 16'd3, 16'd1, 1'b0);
    send_record(16'd3, 16'd2, 16'd2, 1'b0);
    send_record(16'd6, 16'd1, 16'd3, 1'b0);
    send_record(16'd1, 16'd6, 16'd4, 1'b1);
  endtask

  task automatic test_slot_shift();
    for (int i = 1; i <= 5; i++) begin
      send_record(side_t'(i), 16'd1, tag_t'(16'h10 + i), (i == 5));
    end
    send_record(16'd9, 16'd1, 16'h21, 1'b0);
    send_record(16'd7, 16'd1, 16'h22, 1'b0);
    send_record(16'd3, 16'd1, 16'h23, 1'b0);
    send_record(16'd8, 16'd1, 16'h24, 1'b0);
    send_record(16'd5, 16'd1, 16'h25, 1'b1);
  endtask

  task automatic send_random_sets(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        send_record(pick_side(), pick_side(), tag_t'($urandom_range(0, 16'hFFFF)),
                    (i == len - 1));
      end
      sent += len;
    end
  endtask

  task automatic test_random_sets();
    send_idle_pct = 6;
    recv_idle_pct = 63;
    send_random_sets(45);
    send_idle_pct = 63;
    recv_idle_pct = 6;
    send_random_sets(45);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_sets(45);
  endtask

  task automatic test_output_backpressure();
    wait_results_drained();
    long_hold = 1'b1;
    for (int i = 0; i < 24; i++) begin
      send_record(pick_side(), pick_side(), tag_t'($urandom_range(0, 16'hFFFF)), 1'b1);
    end
    wait_results_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 6;
    recv_idle_pct = 63;
    test_extreme_sides();
    test_equal_areas();
    test_slot_shift();
    test_random_sets();
    test_output_backpressure();
    wait_results_drained();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
